// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define BSE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("property violated");

// Check a property on every rising edge, reset included.
`define BSE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("property violated");

`endif

// ===== src/bse_pkg.sv =====
// Shared types and constants of the binary search engine.
`timescale 1ns / 1ps
package bse_pkg;

  localparam int DEPTH_DEF  = 1024;
  localparam int DEPTH_MAX  = 65536;
  localparam int IDX_W      = 10;
  localparam int DATA_W     = 32;
  localparam int S_TDATA_W  = 64;
  localparam int M_TDATA_W  = 8;
  // Range pointers hold values up to the store depth itself.
  localparam int PTR_W      = $clog2(DEPTH_MAX) + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // One classified item waiting for the search core.
  typedef struct packed {
    logic              is_write;
    logic              empty;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
    logic [PTR_W-1:0]  lo;
    logic [PTR_W-1:0]  ehi;   // exclusive end of range
    logic [PTR_W-1:0]  mid;   // first probe
  } entry_t;

endpackage

// ===== src/bse_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module bse_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bse_fifo.sv =====
// Short queue of classified items between front end and search core.
`timescale 1ns / 1ps
module bse_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bse_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output bse_pkg::entry_t entry_o
);
  import bse_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== src/bse_front.sv =====
// Front end: accept items, drop stray writes, set up the search range.
`timescale 1ns / 1ps
module bse_front #(
  parameter int Depth = bse_pkg::DEPTH_DEF
) (
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [9:0] index, [41:10] value, [51:42] low_bound, [61:52] high_bound
  input  logic [bse_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // [0] cmd
  input  logic                          s_axis_tuser_i,
  input  logic                          full_i,
  output logic                          push_o,
  output bse_pkg::entry_t               entry_o
);
  import bse_pkg::*;

  localparam logic [PTR_W-1:0] DepthP = PTR_W'(Depth);
  localparam logic [PTR_W-1:0] LastP  = PTR_W'(Depth - 1);

  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] value;
  logic [PTR_W-1:0]  idx_p, lo_p, hi_p, hi_sat, ehi, span;
  logic              is_write, in_range;

  assign index = s_axis_tdata_i[IDX_W-1:0];
  assign value = s_axis_tdata_i[IDX_W +: DATA_W];
  assign idx_p = PTR_W'(index);
  assign lo_p  = PTR_W'(s_axis_tdata_i[IDX_W + DATA_W +: IDX_W]);
  assign hi_p  = PTR_W'(s_axis_tdata_i[2*IDX_W + DATA_W +: IDX_W]);

  assign is_write = (s_axis_tuser_i == CMD_WRITE);
  assign in_range = (idx_p < DepthP);

  // Hold the range as [lo, ehi) so that it never goes below zero.
  assign hi_sat = (hi_p > LastP) ? LastP : hi_p;
  assign ehi    = hi_sat + 1'b1;
  assign span   = ehi - lo_p - 1'b1;

  always_comb begin
    entry_o.is_write = is_write;
    entry_o.empty    = (lo_p >= ehi);
    entry_o.index    = index;
    entry_o.value    = value;
    entry_o.lo       = lo_p;
    entry_o.ehi      = ehi;
    entry_o.mid      = lo_p + (span >> 1);
  end

  assign s_axis_tready_o = !full_i;
  // Drop a write beyond the store: accept it, queue nothing.
  assign push_o = s_axis_tvalid_i && !full_i && !(is_write && !in_range);

endmodule

// ===== src/bse_back.sv =====
// Search core: carry out writes and probe the store once per cycle.
`timescale 1ns / 1ps
module bse_back #(
  parameter int Depth = bse_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  bse_pkg::entry_t               entry_i,
  output logic                          pop_o,
  output logic                          ram_we_o,
  output logic [$clog2(Depth)-1:0]      ram_waddr_o,
  output logic [bse_pkg::DATA_W-1:0]    ram_wdata_o,
  output logic [$clog2(Depth)-1:0]      ram_raddr_o,
  input  logic [bse_pkg::DATA_W-1:0]    ram_rdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic                          found_o
);
  import bse_pkg::*;

  localparam int AddrW = $clog2(Depth);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [PTR_W-1:0]  lo_q, ehi_q, mid_q;
  logic [DATA_W-1:0] target_q;
  logic              res_q;
  logic              out_valid_q, out_found_q;

  logic              hit, above;
  logic [PTR_W-1:0]  lo_up, gt_mid, le_mid, next_mid, widx;
  logic              gt_empty, le_empty, next_empty;
  logic              load_out;

  // Both halves are prepared in parallel; the compare picks one.
  assign hit      = (ram_rdata_i == target_q);
  assign above    = ($signed(ram_rdata_i) > $signed(target_q));
  assign lo_up    = mid_q + 1'b1;
  assign gt_empty = (lo_q >= mid_q);
  assign le_empty = (lo_up >= ehi_q);
  assign gt_mid   = lo_q + ((mid_q - lo_q - 1'b1) >> 1);
  assign le_mid   = lo_up + ((ehi_q - lo_up - 1'b1) >> 1);
  assign next_mid   = above ? gt_mid : le_mid;
  assign next_empty = above ? gt_empty : le_empty;

  assign pop_o = (state_q == ST_IDLE) && valid_i;
  assign widx  = PTR_W'(entry_i.index);

  assign ram_we_o    = pop_o && entry_i.is_write;
  assign ram_waddr_o = widx[AddrW-1:0];
  assign ram_wdata_o = entry_i.value;
  assign ram_raddr_o = (state_q == ST_SEARCH) ? next_mid[AddrW-1:0] : entry_i.mid[AddrW-1:0];

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lo_q        <= '0;
      ehi_q       <= '0;
      mid_q       <= '0;
      target_q    <= '0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
        out_found_q <= res_q;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o && !entry_i.is_write) begin
            target_q <= entry_i.value;
            lo_q     <= entry_i.lo;
            ehi_q    <= entry_i.ehi;
            mid_q    <= entry_i.mid;
            res_q    <= 1'b0;
            state_q  <= entry_i.empty ? ST_DONE : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (hit) begin
            res_q   <= 1'b1;
            state_q <= ST_DONE;
          end else if (next_empty) begin
            state_q <= ST_DONE;
          end else begin
            if (above) begin
              ehi_q <= mid_q;
            end else begin
              lo_q <= lo_up;
            end
            mid_q <= next_mid;
          end
        end
        ST_DONE: begin
          // Hold the answer until the output register is free.
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign found_o         = out_found_q;

endmodule

// ===== src/binary_search_engine.sv =====
// Binary search engine top level: front end, queue, search core and store.
// A write item (cmd 0) stores one signed 32-bit word at index and gives no
// result; an index at or beyond DEPTH is dropped. A search item (cmd 1)
// looks for value between low_bound and high_bound inclusive (high_bound
// saturates to DEPTH-1) and gives one result item, found in tdata bit 0.
// The store must be sorted ascending over the searched range and every
// probed entry written before. A write is carried out as it leaves the
// queue; a search is set up from the idle state, probes the store (at most
// floor(log2(DEPTH))+1 probes) and then hands its answer to the output
// register, waiting while that register still holds an earlier answer.
// The probes follow one another through the single read port of the
// store: each probe address depends on the word read by the one before.
// A two-entry queue lets the input side take items while a search is
// running.
`timescale 1ns / 1ps
module binary_search_engine #(
  parameter int DEPTH = bse_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [9:0] index, [41:10] value, [51:42] low_bound, [61:52] high_bound, rest zero
  input  logic [bse_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // [0] cmd
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] found, rest zero
  output logic [bse_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import bse_pkg::*;

  localparam int AddrW = $clog2(DEPTH);

  logic              push, full, pop, q_valid;
  entry_t            front_entry, q_entry;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  logic              found;

  bse_front #(.Depth(DEPTH)) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .full_i          (full),
    .push_o          (push),
    .entry_o         (front_entry)
  );

  bse_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  bse_back #(.Depth(DEPTH)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .entry_i         (q_entry),
    .pop_o           (pop),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .found_o         (found)
  );

  bse_ram #(.Width(DATA_W), .Depth(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tdata_o = {{(M_TDATA_W-1){1'b0}}, found};

endmodule

// ===== src/bse_checker.sv =====
// Port-level checks of the binary search engine, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bse_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          s_axis_tuser_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [bse_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import bse_pkg::*;

  // Searches taken in but not yet answered: queue, core and output register.
  localparam int MaxOpen = QUEUE_DEPTH + 2;
  localparam int OpenW   = $clog2(MaxOpen + 2);

  logic [OpenW-1:0] open_q;
  logic             search_in, result_out;

  assign search_in  = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == CMD_SEARCH);
  assign result_out = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (search_in && !result_out) begin
      open_q <= open_q + 1'b1;
    end else if (result_out && !search_in && open_q != '0) begin
      open_q <= open_q - 1'b1;
    end
  end

  `BSE_ASSERT_ALWAYS(a_idle_in_reset, clk_i, !rst_ni |=> !m_axis_tvalid_o)
  `BSE_ASSERT(a_result_held, clk_i, rst_ni,
              m_axis_tvalid_o && !m_axis_tready_i |=>
              m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `BSE_ASSERT(a_pad_zero, clk_i, rst_ni, m_axis_tvalid_o |-> m_axis_tdata_o[M_TDATA_W-1:1] == '0)
  `BSE_ASSERT(a_no_stray_result, clk_i, rst_ni, result_out |-> open_q != '0 || search_in)
  `BSE_ASSERT(a_open_bounded, clk_i, rst_ni, open_q <= OpenW'(MaxOpen))

endmodule

bind binary_search_engine bse_checker u_bse_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
